/* design/smsd_pkg.sv */
// ============================================================================
// smsd_pkg: shared types and constants for the stream mean / stdev core
// Beat layouts, run record, sizing constants and back-end sequencer states.
// ============================================================================
package smsd_pkg;

    // Sample and result formats
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int MAX_COUNT = 65536;
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int MEAN_W    = SAMPLE_W + FRAC_BITS;
    localparam int STD_W     = 24;

    // Front datapath
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int DMAG_W  = SAMPLE_W;
    localparam int D2_W    = 2 * DMAG_W;
    localparam int SUM_W   = 34;
    localparam int SQSUM_W = 49;

    // Queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Back datapath
    localparam int SMAG_W   = SUM_W - 1;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int QLO_W    = 32;
    localparam int HP_W     = SQSUM_W - QLO_W + CNT_W;
    localparam int DEV_W    = PROD_W;
    localparam int DVD_W    = DEV_W + 2 * FRAC_BITS;
    localparam int DVS_W    = 2 * CNT_W - 1;
    localparam int DREM_W   = DVS_W + 1;
    localparam int DCNT_W   = $clog2(DVD_W + 1);
    localparam int RAD_W    = 2 * STD_W;
    localparam int SREM_W   = STD_W + 2;
    localparam int SCNT_W   = $clog2(STD_W + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_beat_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_value;
        logic [STD_W-1:0]         std_dev;
        logic [CNT_W-1:0]         sample_total;
        logic                     overflowed;
    } out_beat_t;

    // Totals of one closed run
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] shift;
        logic signed [SUM_W-1:0]    sum;
        logic [SQSUM_W-1:0]         sqsum;
        logic [CNT_W-1:0]           count;
        logic                       dropped;
    } run_rec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_QLO,
        ST_MUL_QHI,
        ST_MUL_SQ,
        ST_MUL_NN,
        ST_DIV_MEAN_GO,
        ST_DIV_MEAN_WAIT,
        ST_DIV_VAR_GO,
        ST_DIV_VAR_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_EMIT
    } back_state_t;

endpackage

/* design/stream_mean_stdev_core.sv */
// ============================================================================
// stream_mean_stdev_core: streaming mean and standard deviation per run
// Throughput: one sample beat per cycle; each run start costs nothing extra.
// A run's result follows its last beat through the finisher's two 82-step
//   divisions and 24-step square root; runs closing faster than the finisher
//   finishes them fill the two-entry run queue, then stall s_ready.
// Reset (aresetn low, synchronous) empties the queue and awaits a new run.
// ============================================================================
module stream_mean_stdev_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smsd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smsd_pkg::out_beat_t m_data
);
    import smsd_pkg::*;

    logic      q_push;
    run_rec_t  q_push_data;
    logic      q_full;
    logic      q_pop;
    run_rec_t  q_pop_data;
    logic      q_empty;

    smsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    smsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    smsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_pop_data (q_pop_data),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* design/smsd_front.sv */
// ============================================================================
// smsd_front: sample intake and run accumulation
// Stage 1 classifies each beat (run start, counted, dropped) and squares the
// shifted value; stage 2 updates the run totals and pushes a closed run.
// ============================================================================
module smsd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smsd_pkg::in_beat_t  s_data,
    output logic                q_push,
    output smsd_pkg::run_rec_t  q_push_data,
    input  logic                q_full
);
    import smsd_pkg::*;

    // Classify stage
    logic                       open_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SAMPLE_W-1:0] shift_reg;

    logic                       p_valid_reg;
    logic                       p_first_reg;
    logic                       p_drop_reg;
    logic                       p_last_reg;
    logic signed [DIFF_W-1:0]   p_d_reg;
    logic [D2_W-1:0]            p_d2_reg;
    logic signed [SAMPLE_W-1:0] p_shift_reg;
    logic [CNT_W-1:0]           p_count_reg;

    // Accumulate stage
    logic signed [SUM_W-1:0]    acc_sum_reg;
    logic [SQSUM_W-1:0]         acc_sq_reg;
    logic                       acc_drop_reg;
    logic signed [SUM_W-1:0]    acc_sum_next;
    logic [SQSUM_W-1:0]         acc_sq_next;
    logic                       acc_drop_next;

    logic                       s_accept;
    logic                       p_consume;
    logic                       is_first;
    logic                       is_drop;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          diff_mag;
    logic [DMAG_W-1:0]          dmag;

    // Stage 2 drains unless a closing beat finds the queue full
    assign p_consume = p_valid_reg && !(p_last_reg && q_full);
    assign s_ready   = !p_valid_reg || p_consume;
    assign s_accept  = s_valid && s_ready;

    assign is_first = !open_reg;
    assign is_drop  = open_reg && (cnt_reg >= CNT_W'(MAX_COUNT));
    assign diff     = DIFF_W'(s_data.sample) - DIFF_W'(shift_reg);
    assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign dmag     = diff_mag[DMAG_W-1:0];

    // Run tracking and classify register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                p_valid_reg <= 1'b1;
                if (is_first) begin
                    cnt_reg <= CNT_W'(1);
                end else if (!is_drop) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                open_reg <= !s_data.last_sample;
            end else if (p_consume) begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_first_reg <= is_first;
            p_drop_reg  <= is_drop;
            p_last_reg  <= s_data.last_sample;
            p_d_reg     <= diff;
            p_d2_reg    <= dmag * dmag;
            if (is_first) begin
                shift_reg   <= s_data.sample;
                p_shift_reg <= s_data.sample;
                p_count_reg <= CNT_W'(1);
            end else begin
                p_shift_reg <= shift_reg;
                p_count_reg <= is_drop ? cnt_reg : cnt_reg + CNT_W'(1);
            end
        end
    end

    // Totals update
    always_comb begin
        acc_sum_next  = acc_sum_reg;
        acc_sq_next   = acc_sq_reg;
        acc_drop_next = acc_drop_reg;
        if (p_first_reg) begin
            acc_sum_next  = '0;
            acc_sq_next   = '0;
            acc_drop_next = 1'b0;
        end else if (p_drop_reg) begin
            acc_drop_next = 1'b1;
        end else begin
            acc_sum_next = acc_sum_reg + SUM_W'(p_d_reg);
            acc_sq_next  = acc_sq_reg + SQSUM_W'(p_d2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (p_consume) begin
            acc_sum_reg  <= acc_sum_next;
            acc_sq_reg   <= acc_sq_next;
            acc_drop_reg <= acc_drop_next;
        end
    end

    // Closed run goes to the queue
    assign q_push              = p_consume && p_last_reg;
    assign q_push_data.shift   = p_shift_reg;
    assign q_push_data.sum     = acc_sum_next;
    assign q_push_data.sqsum   = acc_sq_next;
    assign q_push_data.count   = p_count_reg;
    assign q_push_data.dropped = acc_drop_next;

endmodule

/* design/smsd_queue.sv */
// ============================================================================
// smsd_queue: run record queue
// Short FIFO of closed-run totals between the front and the back end.
// ============================================================================
module smsd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  smsd_pkg::run_rec_t  push_data,
    output logic                full,
    input  logic                pop,
    output smsd_pkg::run_rec_t  pop_data,
    output logic                empty
);
    import smsd_pkg::*;

    run_rec_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCOUNT_W-1:0]  count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == QCOUNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCOUNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/smsd_div.sv */
// ============================================================================
// smsd_div: radix-2 restoring divider
// One quotient bit per cycle; the dividend register shifts the quotient in.
// ============================================================================
module smsd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [smsd_pkg::DVD_W-1:0]  dividend,
    input  logic [smsd_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [smsd_pkg::DVD_W-1:0]  quotient
);
    import smsd_pkg::*;

    logic [DVD_W-1:0]   dvd_reg;
    logic [DREM_W-1:0]  rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DREM_W-1:0]  rem_shift;
    logic [DREM_W:0]    trial;
    logic               fits;

    // One subtract-and-compare step
    assign rem_shift = {rem_reg[DREM_W-2:0], dvd_reg[DVD_W-1]};
    assign trial     = {1'b0, rem_shift} - (DREM_W + 1)'(dvs_reg);
    assign fits      = !trial[DREM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DCNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial[DREM_W-1:0] : rem_shift;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* design/smsd_sqrt.sv */
// ============================================================================
// smsd_sqrt: digit-by-digit integer square root
// Two radicand bits per cycle, one root bit per cycle, floored result.
// ============================================================================
module smsd_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [smsd_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [smsd_pkg::STD_W-1:0]  root
);
    import smsd_pkg::*;

    logic [RAD_W-1:0]   rad_reg;
    logic [SREM_W-1:0]  rem_reg;
    logic [STD_W-1:0]   root_reg;
    logic [SCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [SREM_W-1:0]  rem_shift;
    logic [SREM_W-1:0]  cand;
    logic [SREM_W:0]    trial;
    logic               fits;

    // Try root bit: remainder against 4*root + 1
    assign rem_shift = {rem_reg[SREM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign cand      = {root_reg, 2'b01};
    assign trial     = {1'b0, rem_shift} - {1'b0, cand};
    assign fits      = !trial[SREM_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == SCNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCNT_W'(STD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SCNT_W'(1);
                if (cnt_reg == SCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? trial[SREM_W-1:0] : rem_shift;
            root_reg <= {root_reg[STD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* design/smsd_back.sv */
// ============================================================================
// smsd_back: run finisher
// Sequencer over a shared 33x33 multiplier, the divider and the square root
// unit; turns one run record into mean and stdev in an output register.
// ============================================================================
module smsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  smsd_pkg::run_rec_t  q_pop_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output smsd_pkg::out_beat_t m_data
);
    import smsd_pkg::*;

    back_state_t                state_reg;
    back_state_t                state_next;

    // Working copy of the run
    logic signed [SAMPLE_W-1:0] shift_reg;
    logic [SQSUM_W-1:0]         sqsum_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       dropped_reg;
    logic                       neg_reg;
    logic [SMAG_W-1:0]          smag_reg;

    // Intermediates
    logic [DEV_W-1:0]           big_reg;
    logic [HP_W-1:0]            hp_reg;
    logic [PROD_W-1:0]          sq_reg;
    logic [DVS_W-1:0]           n2_reg;
    logic [DEV_W-1:0]           dev_reg;
    logic [MEAN_W-1:0]          mean_reg;
    logic [STD_W-1:0]           std_reg;

    logic                       m_valid_reg;
    out_beat_t                  m_data_reg;

    logic [MUL_W-1:0]           mul_a;
    logic [MUL_W-1:0]           mul_b;
    logic [PROD_W-1:0]          prod;
    logic                       div_start;
    logic [DVD_W-1:0]           div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic                       div_done;
    logic [DVD_W-1:0]           div_quot;
    logic                       sqrt_start;
    logic                       sqrt_done;
    logic [STD_W-1:0]           sqrt_root;
    logic                       out_free;
    logic [SUM_W-1:0]           sum_mag;
    logic [MEAN_W-1:0]          mean_q;

    assign out_free = !m_valid_reg || m_ready;
    assign prod     = mul_a * mul_b;
    assign sum_mag  = q_pop_data.sum[SUM_W-1] ? SUM_W'(-q_pop_data.sum)
                                              : SUM_W'(q_pop_data.sum);
    assign mean_q   = div_quot[MEAN_W-1:0];

    smsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    smsd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quot[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:          if (!q_empty) state_next = ST_MUL_QLO;
            ST_MUL_QLO:       state_next = ST_MUL_QHI;
            ST_MUL_QHI:       state_next = ST_MUL_SQ;
            ST_MUL_SQ:        state_next = ST_MUL_NN;
            ST_MUL_NN:        state_next = ST_DIV_MEAN_GO;
            ST_DIV_MEAN_GO:   state_next = ST_DIV_MEAN_WAIT;
            ST_DIV_MEAN_WAIT: if (div_done) state_next = ST_DIV_VAR_GO;
            ST_DIV_VAR_GO:    state_next = ST_DIV_VAR_WAIT;
            ST_DIV_VAR_WAIT:  if (div_done) state_next = ST_SQRT_GO;
            ST_SQRT_GO:       state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:     if (sqrt_done) state_next = ST_EMIT;
            ST_EMIT:          if (out_free) state_next = ST_IDLE;
            default:          state_next = ST_IDLE;
        endcase
    end

    // Control outputs and operand steering
    always_comb begin
        q_pop        = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_start   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = !q_empty;
            end
            ST_MUL_QLO: begin
                mul_a = MUL_W'(sqsum_reg[QLO_W-1:0]);
                mul_b = MUL_W'(count_reg);
            end
            ST_MUL_QHI: begin
                mul_a = MUL_W'(sqsum_reg[SQSUM_W-1:QLO_W]);
                mul_b = MUL_W'(count_reg);
            end
            ST_MUL_SQ: begin
                mul_a = MUL_W'(smag_reg);
                mul_b = MUL_W'(smag_reg);
            end
            ST_MUL_NN: begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(count_reg);
            end
            ST_DIV_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DVD_W'({smag_reg, {FRAC_BITS{1'b0}}});
                div_divisor  = DVS_W'(count_reg);
            end
            ST_DIV_VAR_GO: begin
                div_start    = 1'b1;
                div_dividend = {dev_reg, {(2 * FRAC_BITS){1'b0}}};
                div_divisor  = n2_reg;
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers, loaded by step
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                shift_reg   <= q_pop_data.shift;
                sqsum_reg   <= q_pop_data.sqsum;
                count_reg   <= q_pop_data.count;
                dropped_reg <= q_pop_data.dropped;
                neg_reg     <= q_pop_data.sum[SUM_W-1];
                smag_reg    <= sum_mag[SMAG_W-1:0];
            end
            ST_MUL_QLO: begin
                big_reg <= prod;
            end
            ST_MUL_QHI: begin
                hp_reg <= prod[HP_W-1:0];
            end
            ST_MUL_SQ: begin
                sq_reg  <= prod;
                big_reg <= big_reg + DEV_W'({hp_reg, {QLO_W{1'b0}}});
            end
            ST_MUL_NN: begin
                n2_reg  <= prod[DVS_W-1:0];
                dev_reg <= (big_reg >= sq_reg) ? big_reg - sq_reg : '0;
            end
            ST_DIV_MEAN_WAIT: begin
                if (div_done) begin
                    mean_reg <= {shift_reg, {FRAC_BITS{1'b0}}}
                              + (neg_reg ? MEAN_W'(-mean_q) : mean_q);
                end
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    std_reg <= sqrt_root;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.mean_value   <= mean_reg;
            m_data_reg.std_dev      <= std_reg;
            m_data_reg.sample_total <= count_reg;
            m_data_reg.overflowed   <= dropped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
